FILE: sv/lis_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the longest increasing subsequence block.
// No dependencies; used by lis_cell and the top level.
package lis_pkg;

    localparam int VALUE_W   = 32;
    localparam int LEN_OUT_W = 11;

    // Control bits that travel with each transaction through the cell chain.
    typedef struct packed {
        logic act;    // a real element occupies this stage
        logic start;  // element begins a new sequence
        logic ovf;    // element was dropped because the store was full
    } tok_ctrl_t;

endpackage

FILE: sv/lis_cell.sv
`timescale 1ns / 1ps
// One cell of the systolic chain: holds one stored element and its length.
// Depends on lis_pkg for the control struct and the value width.
module lis_cell #(
    parameter int IDX = 0,
    parameter int IW  = 10,
    parameter int LW  = 11
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  lis_pkg::tok_ctrl_t                 ctrl_in,
    input  logic signed [lis_pkg::VALUE_W-1:0] key_in,
    input  logic [IW-1:0]                      idx_in,
    input  logic [LW-1:0]                      len_in,
    output lis_pkg::tok_ctrl_t                 ctrl_out,
    output logic signed [lis_pkg::VALUE_W-1:0] key_out,
    output logic [IW-1:0]                      idx_out,
    output logic [LW-1:0]                      len_out
);

    logic signed [lis_pkg::VALUE_W-1:0] sv_reg;
    logic [LW-1:0]                      sl_reg;

    lis_pkg::tok_ctrl_t                 ctrl_reg;
    logic signed [lis_pkg::VALUE_W-1:0] key_reg;
    logic [IW-1:0]                      idx_reg;
    logic [LW-1:0]                      len_reg;
    logic [LW-1:0]                      len_next;

    logic live;
    logic store;
    logic earlier;

    assign live    = ctrl_in.act && !ctrl_in.ovf;
    assign store   = live && (idx_in == IW'(IDX));
    // This cell holds an element that came before the one passing through.
    assign earlier = live && (idx_in > IW'(IDX));

    always_comb begin
        len_next = len_in;
        if (earlier && (sv_reg < key_in) && (sl_reg >= len_in)) begin
            len_next = sl_reg + LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && store) begin
            sv_reg <= key_in;
            sl_reg <= len_in;
        end
        if (adv) begin
            key_reg <= key_in;
            idx_reg <= idx_in;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (adv) begin
            ctrl_reg <= ctrl_in;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign key_out  = key_reg;
    assign idx_out  = idx_reg;
    assign len_out  = len_reg;

endmodule

FILE: sv/longest_increasing_subsequence.sv
`timescale 1ns / 1ps
// Longest strictly increasing subsequence over a stream, as a chain of
// MAX_ELEMENTS cells. Each transaction walks the whole chain, one cell per cycle.
// From acceptance, an element passes every cell register and then the output register.
// Throughput: one element per cycle; a stalled output halts the whole chain.
// Reset (aresetn low, synchronous) clears the element count, the best length
// and the chain's occupancy; stored values are not cleared.
module longest_increasing_subsequence #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] start_new
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [10:0] length_ending_here, [21:11] best_length
    output logic [0:0]  m_tuser    // [0] overflow
);

    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int LW = $clog2(MAX_ELEMENTS + 1);
    localparam int OW = lis_pkg::LEN_OUT_W;

    logic adv;
    logic accept;

    logic [LW-1:0] count_reg;
    logic [LW-1:0] count_next;
    logic          full;

    lis_pkg::tok_ctrl_t                 c_ctrl [0:MAX_ELEMENTS];
    logic signed [lis_pkg::VALUE_W-1:0] c_key  [0:MAX_ELEMENTS];
    logic [IW-1:0]                      c_idx  [0:MAX_ELEMENTS];
    logic [LW-1:0]                      c_len  [0:MAX_ELEMENTS];

    logic          m_tvalid_reg;
    logic [OW-1:0] m_len_reg;
    logic [OW-1:0] m_best_reg;
    logic          m_ovf_reg;
    logic [LW-1:0] best_reg;
    logic [LW-1:0] best_next;
    logic [LW+OW-1:0] len_ext;
    logic [LW+OW-1:0] best_ext;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;
    assign full     = (count_reg == LW'(MAX_ELEMENTS));

    // Entry of the chain: the new element starts with length one, or zero if it is dropped as the store is full.
    always_comb begin
        c_ctrl[0].act   = accept;
        c_ctrl[0].start = s_tuser[0];
        c_ctrl[0].ovf   = full && !s_tuser[0];
        c_key[0]        = $signed(s_tdata);
        c_idx[0]        = s_tuser[0] ? '0 : count_reg[IW-1:0];
        c_len[0]        = (full && !s_tuser[0]) ? '0 : LW'(1);
    end

    always_comb begin
        count_next = count_reg;
        if (accept) begin
            if (s_tuser[0]) begin
                count_next = LW'(1);
            end else if (!full) begin
                count_next = count_reg + LW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        lis_cell #(
            .IDX (g),
            .IW  (IW),
            .LW  (LW)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .ctrl_in  (c_ctrl[g]),
            .key_in   (c_key[g]),
            .idx_in   (c_idx[g]),
            .len_in   (c_len[g]),
            .ctrl_out (c_ctrl[g+1]),
            .key_out  (c_key[g+1]),
            .idx_out  (c_idx[g+1]),
            .len_out  (c_len[g+1])
        );
    end

    // The running best is kept in arrival order at the end of the chain.
    always_comb begin
        best_next = best_reg;
        if (c_ctrl[MAX_ELEMENTS].start) begin
            best_next = c_len[MAX_ELEMENTS];
        end else if (c_len[MAX_ELEMENTS] > best_reg) begin
            best_next = c_len[MAX_ELEMENTS];
        end
        len_ext  = {{OW{1'b0}}, c_len[MAX_ELEMENTS]};
        best_ext = {{OW{1'b0}}, best_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            best_reg     <= '0;
        end else if (adv) begin
            m_tvalid_reg <= c_ctrl[MAX_ELEMENTS].act;
            if (c_ctrl[MAX_ELEMENTS].act) begin
                best_reg <= best_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && c_ctrl[MAX_ELEMENTS].act) begin
            m_len_reg  <= len_ext[OW-1:0];
            m_best_reg <= best_ext[OW-1:0];
            m_ovf_reg  <= c_ctrl[MAX_ELEMENTS].ovf;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {2'b00, m_best_reg, m_len_reg};
    assign m_tuser[0] = m_ovf_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LW'(MAX_ELEMENTS))
        else $error("element count exceeds capacity");

    a_start_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] |=> count_reg == LW'(1))
        else $error("start of sequence did not restart the count");

    a_ovf_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[10:0] == 11'd0)
        else $error("dropped element reported a nonzero length");

    a_exit_len: assert property (@(posedge aclk) disable iff (!aresetn)
        c_ctrl[MAX_ELEMENTS].act && !c_ctrl[MAX_ELEMENTS].ovf
        |-> c_len[MAX_ELEMENTS] != '0 && c_len[MAX_ELEMENTS] <= LW'(MAX_ELEMENTS))
        else $error("stored element left the chain with a bad length");
`endif

endmodule
